// File: sv/periodic_task_ready_scan_top_assert.svh
// Assertion macros for the periodic task ready scan block.
`ifndef PERIODIC_TASK_READY_SCAN_TOP_ASSERT_SVH
`define PERIODIC_TASK_READY_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ptrs_pkg.sv
// Shared widths and register index codes of the periodic task ready scan.
package ptrs_pkg;

	localparam int TICK_W    = 32;
	localparam int SLOT_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int REG_SLOTS = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_MASK  = 3'd5;

endpackage

// File: sv/ptrs_due_cmp.sv
// Shared due test: wrapping elapsed tick count compared against the period.
module ptrs_due_cmp
	import ptrs_pkg::*;
(
	input  logic [TICK_W-1:0] now,
	input  logic [TICK_W-1:0] last,
	input  logic [TICK_W-1:0] period,
	output logic              due
);

	logic [TICK_W-1:0] elapsed;

	// Subtraction wraps modulo the tick width.
	assign elapsed = now - last;
	assign due     = (elapsed >= period);

endmodule

// File: sv/periodic_task_ready_scan_top.sv
// An item is taken in IDLE, then a SCAN pass over all SLOTS slots and a FLUSH step follow.
// No new item is taken until the pass is back in IDLE; the single due comparator visits
// one slot per cycle unless stalled; output stalls come only when a second result waits.
// A ready slot is held until the next ready slot of its pass or the flush cycle sends it;
// the final result is loaded into the output register in FLUSH and marked as last.
// Reset clears state, periods, masks and every last tick to zero; no clearing pass.
`include "periodic_task_ready_scan_top_assert.svh"

module periodic_task_ready_scan_top
	import ptrs_pkg::*;
#(
	parameter int SLOTS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [TICK_W-1:0]    cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TICK_W-1:0]    now_tick,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SLOT_W-1:0]    task_slot,
	output logic                 last_of_run
);

	localparam int REG_N = (SLOTS < REG_SLOTS) ? SLOTS : REG_SLOTS;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int REG_W = (REG_N > 1) ? $clog2(REG_N) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t               state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TICK_W-1:0]    now_q;
	logic [TICK_W-1:0]    period_q [REG_N];
	logic [TICK_W-1:0]    last_tick_q [REG_N];
	logic [REG_N-1:0]     enable_q;
	logic [REG_N-1:0]     pause_q;
	logic                 pend_valid_q;
	logic [SLOT_W-1:0]    pend_slot_q;
	logic                 out_valid_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 out_last_q;

	logic [REG_W-1:0]     reg_idx;
	logic                 has_reg;
	logic                 due;
	logic                 hit;
	logic                 out_free;
	logic                 step_ok;
	logic                 out_load;
	logic                 out_load_last;
	logic                 in_take;
	logic                 period_wr;

	assign reg_idx   = idx_q[REG_W-1:0];
	assign has_reg   = (int'(idx_q) < REG_N);
	assign out_free  = !out_valid_q || out_ready;
	assign step_ok   = !pend_valid_q || out_free;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign period_wr = cfg_wen && (cfg_addr < CFG_IDX_W'(REG_N));

	ptrs_due_cmp u_due_cmp (
		.now    (now_q),
		.last   (last_tick_q[reg_idx]),
		.period (period_q[reg_idx]),
		.due    (due)
	);

	assign hit = (state_q == ST_SCAN) && has_reg && enable_q[reg_idx]
		&& !pause_q[reg_idx] && due;

	// A pending result goes out when a later hit proves it is not the last,
	// or at flush time marked as last.
	always_comb begin
		out_load      = 1'b0;
		out_load_last = 1'b0;
		case (state_q)
			ST_SCAN: begin
				out_load = step_ok && hit && pend_valid_q;
			end
			ST_FLUSH: begin
				out_load      = step_ok && pend_valid_q;
				out_load_last = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (step_ok) begin
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						if (idx_q == IDX_W'(SLOTS - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (step_ok) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample the tick once per pass.
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q <= now_tick;
		end
		if (step_ok && hit) begin
			pend_slot_q <= SLOT_W'(reg_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_N; i++) begin
				period_q[i]    <= '0;
				last_tick_q[i] <= '0;
			end
			enable_q <= '0;
			pause_q  <= '0;
		end else begin
			if (period_wr) begin
				period_q[cfg_addr[REG_W-1:0]] <= cfg_wdata;
			end
			if (cfg_wen && (cfg_addr == REG_ENABLE_MASK)) begin
				enable_q <= cfg_wdata[REG_N-1:0];
			end
			if (cfg_wen && (cfg_addr == REG_PAUSE_MASK)) begin
				pause_q <= cfg_wdata[REG_N-1:0];
			end
			if (step_ok && hit) begin
				last_tick_q[reg_idx] <= now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q <= pend_slot_q;
			out_last_q <= out_load_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign task_slot   = out_slot_q;
	assign last_of_run = out_last_q;

	`PTRS_ASSERT_NOW(a_idle_no_pending, state_q == ST_IDLE, !pend_valid_q,
		"pending item left in idle")
	`PTRS_ASSERT_NEXT(a_take_starts_scan, in_take, state_q == ST_SCAN && idx_q == '0,
		"pass did not start at slot zero")
	`PTRS_ASSERT_NEXT(a_hit_pushes_unmarked,
		state_q == ST_SCAN && step_ok && hit && pend_valid_q,
		out_valid_q && !out_last_q, "earlier ready slot not sent unmarked")
	`PTRS_ASSERT_NEXT(a_flush_marks_last, state_q == ST_FLUSH && step_ok && pend_valid_q,
		out_valid_q && out_last_q && state_q == ST_IDLE, "final ready slot not marked")

endmodule
